// File: rtl/lh_pkg.sv
package lh_pkg;

  // operation codes of the input channel
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 32;
  localparam int BKT_W    = 4;
  localparam int OUT_CW   = 32;
  localparam int SUM_W    = 48;
  localparam int EDGE_W   = 20;
  localparam int EDGE_N   = 15;

  localparam logic [SUM_W-1:0]    SUM_MAX  = '1;
  localparam logic [SAMPLE_W-1:0] MIN_INIT = '1;

  // upper edge of each bucket but the overflow bucket, in microseconds
  localparam logic [EDGE_W-1:0] EDGE_US [EDGE_N] = '{
    20'd10,     20'd50,     20'd100,    20'd200,    20'd500,
    20'd1000,   20'd2000,   20'd5000,   20'd10000,  20'd20000,
    20'd50000,  20'd100000, 20'd200000, 20'd500000, 20'd1000000
  };

endpackage

// File: rtl/lh_if.sv
interface lh_in_if;
  logic                        valid;
  logic                        ready;
  logic [lh_pkg::OP_W-1:0]     operation;
  logic [lh_pkg::SAMPLE_W-1:0] sample_us;
  logic [lh_pkg::BKT_W-1:0]    read_bucket;

  modport source (output valid, output operation, output sample_us, output read_bucket,
                  input ready);
  modport sink   (input valid, input operation, input sample_us, input read_bucket,
                  output ready);
endinterface

interface lh_out_if;
  logic                        valid;
  logic                        ready;
  logic [lh_pkg::BKT_W-1:0]    bucket;
  logic [lh_pkg::OUT_CW-1:0]   bucket_count;
  logic [lh_pkg::OUT_CW-1:0]   total_count;
  logic [lh_pkg::SUM_W-1:0]    sum_us;
  logic [lh_pkg::SAMPLE_W-1:0] min_us;
  logic [lh_pkg::SAMPLE_W-1:0] max_us;

  modport source (output valid, output bucket, output bucket_count, output total_count,
                  output sum_us, output min_us, output max_us, input ready);
  modport sink   (input valid, input bucket, input bucket_count, input total_count,
                  input sum_us, input min_us, input max_us, output ready);
endinterface

// File: rtl/latency_histogram_top.sv
// channel   dir  handshake          payload
// in_ch     in   valid/ready        operation, sample_us, read_bucket
// out_ch    out  valid/ready        bucket, bucket_count, total_count, sum_us, min_us, max_us
//
// one item per cycle while out_ch does not stall; a result passes stage 1 and the result
// register; the count memory is read at transfer and written back as the item leaves
// stage 1, with a bypass when the write of the previous item lands on the same bucket
// reset clears the totals and every per-bucket valid bit at once, so no clearing pass
// a stalled output holds the result register and the stage behind it, then in_ch stalls
module latency_histogram_top #(
  parameter int NUM_BUCKETS = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  lh_in_if.sink         in_ch,
  lh_out_if.source      out_ch
);

  localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  // input transfer and bucket pick
  logic                        in_xfer;
  logic [lh_pkg::BKT_W-1:0]    sel_bkt;
  logic [IDX_W-1:0]            rd_addr;
  logic                        s1_adv;

  // stage 1 registers
  logic                        s1_vld_r;
  logic [lh_pkg::OP_W-1:0]     s1_op_r;
  logic [lh_pkg::BKT_W-1:0]    s1_bkt_r;
  logic                        s1_inrng_r;
  logic [lh_pkg::SAMPLE_W-1:0] s1_sample_r;

  lh_bucket_sel #(.NUM_BUCKETS(NUM_BUCKETS)) u_sel (
    .sample_us (in_ch.sample_us),
    .bucket    (sel_bkt)
  );

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign rd_addr     = (in_ch.operation == lh_pkg::OP_RECORD) ? sel_bkt[IDX_W-1:0]
                                                               : in_ch.read_bucket[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r     <= in_ch.operation;
      s1_bkt_r    <= (in_ch.operation == lh_pkg::OP_RECORD) ? sel_bkt : in_ch.read_bucket;
      s1_inrng_r  <= ({1'b0, in_ch.read_bucket} < (lh_pkg::BKT_W + 1)'(NUM_BUCKETS));
      s1_sample_r <= in_ch.sample_us;
    end
  end

  // count memory, valid bits and write bypass
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_BUCKETS];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [NUM_BUCKETS-1:0] cnt_vld_r;
  logic                   fwd_hit_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   is_clear;
  logic                   is_record;

  assign wr_en   = s1_adv && is_record;
  assign wr_addr = s1_bkt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (in_xfer) begin
      rd_data_r  <= cnt_mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_xfer) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (s1_adv && is_clear) begin
      cnt_vld_r <= '0;
    end else if (wr_en) begin
      cnt_vld_r[wr_addr] <= 1'b1;
    end
  end

  // statistics registers
  logic [COUNT_WIDTH-1:0]      total_r,  total_nxt;
  logic [lh_pkg::SUM_W-1:0]    sum_r,    sum_nxt;
  logic [lh_pkg::SAMPLE_W-1:0] min_r,    min_nxt;
  logic [lh_pkg::SAMPLE_W-1:0] max_r,    max_nxt;
  logic [COUNT_WIDTH-1:0]      cnt_cur;
  logic [COUNT_WIDTH-1:0]      cnt_res;
  logic [lh_pkg::SUM_W:0]      sum_add;

  assign is_clear  = (s1_op_r == lh_pkg::OP_CLEAR);
  assign is_record = (s1_op_r == lh_pkg::OP_RECORD);
  assign cnt_cur   = !cnt_vld_r[s1_bkt_r[IDX_W-1:0]] ? '0 :
                     fwd_hit_r ? fwd_data_r : rd_data_r;
  assign wr_data   = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
  assign sum_add   = {1'b0, sum_r} + (lh_pkg::SUM_W + 1)'(s1_sample_r);

  // update on the stage 1 operation
  always_comb begin
    total_nxt = total_r;
    sum_nxt   = sum_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    cnt_res   = '0;
    case (s1_op_r)
      lh_pkg::OP_RECORD: begin
        total_nxt = (&total_r) ? total_r : total_r + COUNT_WIDTH'(1);
        sum_nxt   = (sum_add >= {1'b0, lh_pkg::SUM_MAX}) ? lh_pkg::SUM_MAX
                                                        : sum_add[lh_pkg::SUM_W-1:0];
        if (s1_sample_r < min_r) begin
          min_nxt = s1_sample_r;
        end
        if (s1_sample_r > max_r) begin
          max_nxt = s1_sample_r;
        end
        cnt_res = wr_data;
      end
      lh_pkg::OP_CLEAR: begin
        total_nxt = '0;
        sum_nxt   = '0;
        min_nxt   = lh_pkg::MIN_INIT;
        max_nxt   = '0;
      end
      default: begin
        cnt_res = s1_inrng_r ? cnt_cur : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      sum_r   <= '0;
      min_r   <= lh_pkg::MIN_INIT;
      max_r   <= '0;
    end else if (s1_adv) begin
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // result register
  logic                        out_vld_r;
  logic [lh_pkg::BKT_W-1:0]    out_bkt_r;
  logic [lh_pkg::OUT_CW-1:0]   out_cnt_r;
  logic [lh_pkg::OUT_CW-1:0]   out_total_r;
  logic [lh_pkg::SUM_W-1:0]    out_sum_r;
  logic [lh_pkg::SAMPLE_W-1:0] out_min_r;
  logic [lh_pkg::SAMPLE_W-1:0] out_max_r;

  assign s1_adv = s1_vld_r && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bkt_r   <= is_clear ? '0 : s1_bkt_r;
      out_cnt_r   <= lh_pkg::OUT_CW'(cnt_res);
      out_total_r <= lh_pkg::OUT_CW'(total_nxt);
      out_sum_r   <= sum_nxt;
      out_min_r   <= (total_nxt == '0) ? '0 : min_nxt;
      out_max_r   <= max_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.bucket       = out_bkt_r;
  assign out_ch.bucket_count = out_cnt_r;
  assign out_ch.total_count  = out_total_r;
  assign out_ch.sum_us       = out_sum_r;
  assign out_ch.min_us       = out_min_r;
  assign out_ch.max_us       = out_max_r;

  // checks
  a_clear_drops_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && is_clear |=> cnt_vld_r == '0)
    else $error("bucket valid bits survive a clear");

  a_bypass_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && fwd_hit_r |-> cnt_vld_r[s1_bkt_r[IDX_W-1:0]])
    else $error("bypass hit on a bucket that is not valid");

  a_max_needs_total: assert property (@(posedge clk) disable iff (!rst_n)
    max_r != '0 |-> total_r != '0)
    else $error("maximum set with no recorded sample");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r != '0 |-> min_r <= max_r)
    else $error("minimum above maximum");

endmodule

// File: rtl/lh_bucket_sel.sv
module lh_bucket_sel #(
  parameter int NUM_BUCKETS = 16
) (
  input  logic [lh_pkg::SAMPLE_W-1:0] sample_us,
  output logic [lh_pkg::BKT_W-1:0]    bucket
);

  logic [NUM_BUCKETS-2:0] hit;

  // one comparator per used edge
  always_comb begin
    for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
      hit[i] = (sample_us <= lh_pkg::SAMPLE_W'(lh_pkg::EDGE_US[i]));
    end
  end

  // first edge that holds the sample, overflow bucket otherwise
  always_comb begin
    bucket = lh_pkg::BKT_W'(NUM_BUCKETS - 1);
    for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
      if (hit[i]) begin
        bucket = lh_pkg::BKT_W'(i);
      end
    end
  end

endmodule
